[src/sljfp_pkg.sv]
package sljfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 128;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd85;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC  = 1'b0,
    CFG_SECOND_SYNC = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               result_kind;
    logic [BYTE_W-1:0]   frame_command;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  payload_index;
    logic [BYTE_W-1:0]   frame_length;
    logic                check_passed;
  } res_t;

  typedef struct packed {
    logic              fire;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

endpackage

[src/sljfp_stream_if.sv]
interface sljfp_rx_if;
  logic                       valid;
  logic                       ready;
  logic [sljfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sljfp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [sljfp_pkg::BYTE_W-1:0]  frame_command;
  logic [sljfp_pkg::BYTE_W-1:0]  payload_byte;
  logic [sljfp_pkg::INDEX_W-1:0] payload_index;
  logic [sljfp_pkg::BYTE_W-1:0]  frame_length;
  logic                        check_passed;

  modport source (
    output valid, output result_kind, output frame_command, output payload_byte,
    output payload_index, output frame_length, output check_passed, input ready
  );
  modport sink (
    input valid, input result_kind, input frame_command, input payload_byte,
    input payload_index, input frame_length, input check_passed, output ready
  );
endinterface

[src/sljfp_in_stage.sv]
module sljfp_in_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [sljfp_pkg::BYTE_W-1:0] in_byte_i,
  output logic                         in_ready_o,
  input  logic                         out_free_i,
  output sljfp_pkg::stage_t            stage_o
);

  logic                         valid_q;
  logic [sljfp_pkg::BYTE_W-1:0] byte_q;
  logic                         fire;

  assign fire       = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (fire) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign stage_o.fire    = fire;
  assign stage_o.rx_byte = byte_q;

endmodule

[src/sljfp_parser.sv]
module sljfp_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sljfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sljfp_pkg::BYTE_W-1:0]    cfg_data_i,
  input  sljfp_pkg::stage_t               stage_i,
  output logic                            res_valid_o,
  output sljfp_pkg::res_t                 res_o
);

  logic [sljfp_pkg::BYTE_W-1:0] first_sync_q, second_sync_q;
  sljfp_pkg::phase_e            phase_q, phase_d;
  logic [sljfp_pkg::BYTE_W-1:0] cmd_q, cmd_d;
  logic [sljfp_pkg::BYTE_W-1:0] len_q, len_d;
  logic [sljfp_pkg::BYTE_W-1:0] pos_q, pos_d;
  logic [sljfp_pkg::BYTE_W-1:0] xor_q, xor_d;
  logic [sljfp_pkg::BYTE_W-1:0] b;
  logic [sljfp_pkg::BYTE_W-1:0] pos_inc;

  assign b       = stage_i.rx_byte;
  assign pos_inc = pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q  <= sljfp_pkg::FIRST_SYNC_RST;
      second_sync_q <= sljfp_pkg::SECOND_SYNC_RST;
    end else if (cfg_we_i) begin
      unique case (sljfp_pkg::cfg_reg_e'(cfg_idx_i))
        sljfp_pkg::CFG_FIRST_SYNC:  first_sync_q  <= cfg_data_i;
        sljfp_pkg::CFG_SECOND_SYNC: second_sync_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sljfp_pkg::PH_SYNC1;
      cmd_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      xor_q   <= '0;
    end else if (stage_i.fire) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    pos_d       = pos_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o.result_kind   = sljfp_pkg::KIND_PAYLOAD;
    res_o.frame_command = cmd_q;
    res_o.payload_byte  = '0;
    res_o.payload_index = '0;
    res_o.frame_length  = len_q;
    res_o.check_passed  = 1'b0;
    unique case (phase_q)
      sljfp_pkg::PH_SYNC1: begin
        if (b == first_sync_q) phase_d = sljfp_pkg::PH_SYNC2;
      end
      sljfp_pkg::PH_SYNC2: begin
        if (b == second_sync_q) begin
          phase_d = sljfp_pkg::PH_CMD;
        end else if (b == first_sync_q) begin
          phase_d = sljfp_pkg::PH_SYNC2;
        end else begin
          phase_d = sljfp_pkg::PH_SYNC1;
        end
      end
      sljfp_pkg::PH_CMD: begin
        cmd_d   = b;
        xor_d   = b;
        phase_d = sljfp_pkg::PH_LEN;
      end
      sljfp_pkg::PH_LEN: begin
        len_d = b;
        xor_d = xor_q ^ b;
        pos_d = '0;
        if (b > sljfp_pkg::BYTE_W'(sljfp_pkg::MAX_PAYLOAD)) begin
          phase_d = sljfp_pkg::PH_SYNC1;
        end else if (b != '0) begin
          phase_d = sljfp_pkg::PH_PAYLOAD;
        end else begin
          phase_d = sljfp_pkg::PH_CHECK;
        end
      end
      sljfp_pkg::PH_PAYLOAD: begin
        res_valid_o         = 1'b1;
        res_o.payload_byte  = b;
        res_o.payload_index = pos_q[sljfp_pkg::INDEX_W-1:0];
        xor_d = xor_q ^ b;
        pos_d = pos_inc;
        if (pos_inc >= len_q) phase_d = sljfp_pkg::PH_CHECK;
      end
      sljfp_pkg::PH_CHECK: begin
        res_valid_o        = 1'b1;
        res_o.result_kind  = sljfp_pkg::KIND_FRAME_END;
        res_o.check_passed = (b == xor_q);
        phase_d            = sljfp_pkg::PH_SYNC1;
      end
      default: begin
        phase_d = sljfp_pkg::PH_SYNC1;
      end
    endcase
  end

endmodule

[src/sljfp_out_reg.sv]
module sljfp_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            res_valid_i,
  input  sljfp_pkg::res_t res_i,
  output logic            out_free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sljfp_pkg::res_t out_o
);

  logic            valid_q;
  sljfp_pkg::res_t res_q;
  logic            load;

  assign out_free_o  = ~valid_q | out_ready_i;
  assign load        = fire_i & res_valid_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

endmodule

[src/sync_length_xor_frame_parser.sv]
// channel   dir  payload                                        width
// rx_i      in   rx_byte                                        8
// res_o     out  result_kind, frame_command, payload_byte,      1+8+8
//                payload_index, frame_length, check_passed      +7+8+1
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                1+1+8
//
// one word per cycle sustained while results are taken; a word is taken into
// the input register, then parsed on its way into the result register, which
// offers its result
// a waiting result stops the parser; the input register takes one more word,
// then input stalls until the result is taken
// reset clears the phase to the first sync hunt and loads sync values 0xaa, 0x55
module sync_length_xor_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sljfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sljfp_pkg::BYTE_W-1:0]    cfg_data_i,
  sljfp_rx_if.sink                        rx_i,
  sljfp_res_if.source                     res_o
);

  sljfp_pkg::stage_t stage;
  logic              out_free;
  logic              res_valid;
  sljfp_pkg::res_t   res;
  sljfp_pkg::res_t   out_res;

  sljfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .out_free_i (out_free),
    .stage_o    (stage)
  );

  sljfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sljfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (stage.fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (out_res)
  );

  assign res_o.result_kind   = out_res.result_kind;
  assign res_o.frame_command = out_res.frame_command;
  assign res_o.payload_byte  = out_res.payload_byte;
  assign res_o.payload_index = out_res.payload_index;
  assign res_o.frame_length  = out_res.frame_length;
  assign res_o.check_passed  = out_res.check_passed;

endmodule

[src/sljfp_checker.sv]
module sljfp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           result_kind_i,
  input logic [sljfp_pkg::BYTE_W-1:0]   frame_command_i,
  input logic [sljfp_pkg::BYTE_W-1:0]   payload_byte_i,
  input logic [sljfp_pkg::INDEX_W-1:0]  payload_index_i,
  input logic [sljfp_pkg::BYTE_W-1:0]   frame_length_i,
  input logic                           check_passed_i
);

  logic payload_word;
  logic end_word;

  assign payload_word = out_valid_i && (result_kind_i == sljfp_pkg::KIND_PAYLOAD);
  assign end_word     = out_valid_i && (result_kind_i == sljfp_pkg::KIND_FRAME_END);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i)
      && $stable(frame_command_i) && $stable(payload_byte_i)
      && $stable(payload_index_i) && $stable(frame_length_i) && $stable(check_passed_i))
    else $error("result word changed while stalled");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_word |-> payload_byte_i == '0 && payload_index_i == '0)
    else $error("frame end carries payload data");

  a_payload_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_word |-> !check_passed_i
      && {1'b0, payload_index_i} < frame_length_i)
    else $error("payload index outside frame length");

  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_length_i <= sljfp_pkg::BYTE_W'(sljfp_pkg::MAX_PAYLOAD))
    else $error("result from frame with length over limit");

endmodule

bind sync_length_xor_frame_parser sljfp_checker u_sljfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .result_kind_i   (res_o.result_kind),
  .frame_command_i (res_o.frame_command),
  .payload_byte_i  (res_o.payload_byte),
  .payload_index_i (res_o.payload_index),
  .frame_length_i  (res_o.frame_length),
  .check_passed_i  (res_o.check_passed)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned IDLE_PCT          = 12;
  localparam int unsigned SINK_HOLD         = 80;
  localparam int unsigned N_SETTINGS        = 6;
  localparam int unsigned WORDS_PER_SETTING = 300;
  localparam int unsigned LONG_FRAME_LEN    = 64;
  localparam int unsigned DRAIN_CYCLES      = 6;

  typedef struct packed {
    logic [sljfp_pkg::BYTE_W-1:0] rx;
    logic                         typed;
    logic                         has_res;
    sljfp_pkg::res_t              want;
  } dir_row_t;

  localparam sljfp_pkg::res_t NO_WORD = '0;

  localparam dir_row_t DIR_ROWS [26] = '{
    '{8'h00, 1'b1, 1'b0, NO_WORD},  // noise while hunting
    '{8'hAA, 1'b1, 1'b0, NO_WORD},
    '{8'hAA, 1'b1, 1'b0, NO_WORD},  // repeated first sync
    '{8'h55, 1'b1, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b0, NO_WORD},  // zero length
    '{8'hFF, 1'b1, 1'b1,
      '{sljfp_pkg::KIND_FRAME_END, 8'hFF, 8'h00, 7'd0, 8'h00, 1'b1}},
    '{8'hAA, 1'b1, 1'b0, NO_WORD},
    '{8'h12, 1'b1, 1'b0, NO_WORD},  // bad second sync
    '{8'hAA, 1'b1, 1'b0, NO_WORD},
    '{8'h55, 1'b1, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b0, NO_WORD},
    '{8'h81, 1'b1, 1'b0, NO_WORD},  // length over the limit
    '{8'hAA, 1'b1, 1'b0, NO_WORD},
    '{8'h55, 1'b1, 1'b0, NO_WORD},
    '{8'h80, 1'b1, 1'b0, NO_WORD},
    '{8'h02, 1'b1, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b1,
      '{sljfp_pkg::KIND_PAYLOAD, 8'h80, 8'h00, 7'd0, 8'h02, 1'b0}},
    '{8'hFF, 1'b1, 1'b1,
      '{sljfp_pkg::KIND_PAYLOAD, 8'h80, 8'hFF, 7'd1, 8'h02, 1'b0}},
    '{8'h00, 1'b1, 1'b1,
      '{sljfp_pkg::KIND_FRAME_END, 8'h80, 8'h00, 7'd0, 8'h02, 1'b0}},
    '{8'hAA, 1'b1, 1'b0, NO_WORD},
    '{8'h55, 1'b1, 1'b0, NO_WORD},
    '{8'h5A, 1'b1, 1'b0, NO_WORD},
    '{8'h01, 1'b1, 1'b0, NO_WORD},
    '{8'h3C, 1'b0, 1'b0, NO_WORD},
    '{8'h67, 1'b0, 1'b0, NO_WORD}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i;
  logic [sljfp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sljfp_pkg::BYTE_W-1:0]    cfg_data_i;

  sljfp_rx_if  rx_if ();
  sljfp_res_if res_if ();

  sync_length_xor_frame_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser state as predicted
  logic [sljfp_pkg::BYTE_W-1:0] sync1_cfg = sljfp_pkg::FIRST_SYNC_RST;
  logic [sljfp_pkg::BYTE_W-1:0] sync2_cfg = sljfp_pkg::SECOND_SYNC_RST;
  sljfp_pkg::phase_e            rx_phase  = sljfp_pkg::PH_SYNC1;
  logic [sljfp_pkg::BYTE_W-1:0] cur_cmd   = '0;
  logic [sljfp_pkg::BYTE_W-1:0] cur_len   = '0;
  logic [sljfp_pkg::BYTE_W-1:0] cur_pos   = '0;
  logic [sljfp_pkg::BYTE_W-1:0] cur_xor   = '0;

  sljfp_pkg::res_t frame_q [$];
  sljfp_pkg::res_t head_w;
  bit              calm = 1'b0;
  int unsigned     hold_asked = 0;
  int unsigned     hold_done = 0;
  int unsigned     hold_left = 0;
  int unsigned     mismatches = 0;
  int unsigned     words_sent = 0;
  int unsigned     live_words = 0;
  int unsigned     payload_words = 0;
  int unsigned     frame_ends = 0;
  int unsigned     frames_passed = 0;

  function automatic bit predict_word(input logic [sljfp_pkg::BYTE_W-1:0] b,
                                      output sljfp_pkg::res_t w);
    bit has;
    has = 1'b0;
    w   = '0;
    case (rx_phase)
      sljfp_pkg::PH_SYNC1: begin
        if (b == sync1_cfg) rx_phase = sljfp_pkg::PH_SYNC2;
      end
      sljfp_pkg::PH_SYNC2: begin
        if (b == sync2_cfg) rx_phase = sljfp_pkg::PH_CMD;
        else if (b != sync1_cfg) rx_phase = sljfp_pkg::PH_SYNC1;
      end
      sljfp_pkg::PH_CMD: begin
        cur_cmd  = b;
        cur_xor  = b;
        rx_phase = sljfp_pkg::PH_LEN;
      end
      sljfp_pkg::PH_LEN: begin
        cur_len = b;
        cur_xor = cur_xor ^ b;
        cur_pos = '0;
        if (b > sljfp_pkg::MAX_PAYLOAD) rx_phase = sljfp_pkg::PH_SYNC1;
        else if (b == 0) rx_phase = sljfp_pkg::PH_CHECK;
        else rx_phase = sljfp_pkg::PH_PAYLOAD;
      end
      sljfp_pkg::PH_PAYLOAD: begin
        w.result_kind   = sljfp_pkg::KIND_PAYLOAD;
        w.frame_command = cur_cmd;
        w.payload_byte  = b;
        w.payload_index = cur_pos[sljfp_pkg::INDEX_W-1:0];
        w.frame_length  = cur_len;
        has     = 1'b1;
        cur_xor = cur_xor ^ b;
        cur_pos = cur_pos + 1'b1;
        if (cur_pos >= cur_len) rx_phase = sljfp_pkg::PH_CHECK;
      end
      sljfp_pkg::PH_CHECK: begin
        w.result_kind   = sljfp_pkg::KIND_FRAME_END;
        w.frame_command = cur_cmd;
        w.frame_length  = cur_len;
        w.check_passed  = (b == cur_xor);
        has      = 1'b1;
        rx_phase = sljfp_pkg::PH_SYNC1;
      end
      default: rx_phase = sljfp_pkg::PH_SYNC1;
    endcase
    return has;
  endfunction

  // offer one word, return right after the edge that takes it
  task automatic offer_word(input logic [sljfp_pkg::BYTE_W-1:0] b);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    words_sent++;
    if (rx_phase != sljfp_pkg::PH_SYNC1 || b == sync1_cfg) live_words++;
  endtask

  task automatic send_word(input logic [sljfp_pkg::BYTE_W-1:0] b);
    sljfp_pkg::res_t w;
    offer_word(b);
    if (predict_word(b, w)) frame_q.push_back(w);
  endtask

  task automatic settle_block();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_syncs(input logic [sljfp_pkg::BYTE_W-1:0] s1,
                               input logic [sljfp_pkg::BYTE_W-1:0] s2);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sljfp_pkg::CFG_FIRST_SYNC;
    cfg_data_i <= s1;
    @(posedge clk_i);
    cfg_idx_i  <= sljfp_pkg::CFG_SECOND_SYNC;
    cfg_data_i <= s2;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sync1_cfg = s1;
    sync2_cfg = s2;
  endtask

  // mostly well-formed frames, some noise, broken headers and bad checks
  task automatic send_random_frame(input bit long_frame);
    int unsigned pick;
    int unsigned len;
    logic [sljfp_pkg::BYTE_W-1:0] cmd;
    logic [sljfp_pkg::BYTE_W-1:0] sum;
    logic [sljfp_pkg::BYTE_W-1:0] b;
    pick = long_frame ? 99 : $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)));
      return;
    end
    send_word(sync1_cfg);
    if (pick < 20) repeat ($urandom_range(1, 2)) send_word(sync1_cfg);
    if (pick >= 20 && pick < 28) begin
      send_word(8'($urandom_range(255)));
      return;
    end
    send_word(sync2_cfg);
    cmd = 8'($urandom_range(255));
    send_word(cmd);
    pick = $urandom_range(99);
    if (long_frame) len = LONG_FRAME_LEN;
    else if (pick < 5) len = $urandom_range(sljfp_pkg::MAX_PAYLOAD + 1, 255);
    else if (pick < 6) len = sljfp_pkg::MAX_PAYLOAD;
    else if (pick < 9) len = 0;
    else if (pick < 12) len = $urandom_range(9, sljfp_pkg::MAX_PAYLOAD - 1);
    else len = $urandom_range(1, 8);
    send_word(len[sljfp_pkg::BYTE_W-1:0]);
    if (len > sljfp_pkg::MAX_PAYLOAD) return;
    sum = cmd ^ len[sljfp_pkg::BYTE_W-1:0];
    repeat (len) begin
      b   = 8'($urandom_range(255));
      sum = sum ^ b;
      send_word(b);
    end
    send_word(($urandom_range(99) < 85) ? sum : 8'($urandom_range(255)));
  endtask

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      res_if.ready <= 1'b0;
      hold_done    <= hold_done + 1;
      hold_left    <= SINK_HOLD;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [sljfp_pkg::BYTE_W-1:0] want,
                             input logic [sljfp_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (frame_q.size() == 0) begin
        mismatches++;
        $display("%0t: word with none expected, expected nothing, got kind %0d cmd 'h%0h",
                 $time, res_if.result_kind, res_if.frame_command);
      end else begin
        head_w = frame_q.pop_front();
        check_field("result_kind", head_w.result_kind, res_if.result_kind);
        check_field("frame_command", head_w.frame_command, res_if.frame_command);
        check_field("payload_byte", head_w.payload_byte, res_if.payload_byte);
        check_field("payload_index", head_w.payload_index, res_if.payload_index);
        check_field("frame_length", head_w.frame_length, res_if.frame_length);
        check_field("check_passed", head_w.check_passed, res_if.check_passed);
        if (head_w.result_kind == sljfp_pkg::KIND_FRAME_END) begin
          frame_ends++;
          if (head_w.check_passed) frames_passed++;
        end else begin
          payload_words++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sljfp_pkg::res_t              w;
    bit                           has;
    logic [sljfp_pkg::BYTE_W-1:0] v;
    int unsigned                  s;
    int unsigned                  goal;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sljfp_pkg::CFG_FIRST_SYNC;
    cfg_data_i    = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      offer_word(DIR_ROWS[i].rx);
      has = predict_word(DIR_ROWS[i].rx, w);
      if (DIR_ROWS[i].typed) begin
        if (DIR_ROWS[i].has_res) frame_q.push_back(DIR_ROWS[i].want);
      end else if (has) begin
        frame_q.push_back(w);
      end
    end
    settle_block();

    for (s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: program_syncs(8'h00, 8'hFF);
        1: program_syncs(8'hFF, 8'h00);
        2: begin
          v = 8'($urandom_range(255));
          program_syncs(v, v);
        end
        default: program_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      calm = (s == 3);
      if (s == 1) begin
        hold_asked++;
        send_random_frame(1'b1);
      end
      goal = live_words + WORDS_PER_SETTING;
      while (live_words < goal) send_random_frame(1'b0);
      settle_block();
    end
    calm = 1'b0;

    $display("run fed %0d words (%0d past the hunt) under %0d sync settings",
             words_sent, live_words, N_SETTINGS + 1);
    $display("checked %0d payload words and %0d frame ends, %0d with a good check",
             payload_words, frame_ends, frames_passed);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
